// ===== hdl/b64d_pkg.sv =====
// Shared types, constants and the character map for the base64url stream decoder.
package b64d_pkg;

    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 16;
    localparam int ADDR_W  = 3;
    localparam int APB_W   = 32;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'hFFFF;
    localparam logic [CHAR_W-1:0]  BAD_VALUE   = 8'hFF;
    localparam logic [CHAR_W-1:0]  CODE_DASH   = 8'd62;
    localparam logic [CHAR_W-1:0]  CODE_SLASH  = 8'd63;

    // Register index, taken from byte address bit 2
    localparam logic REG_OUT_LIMIT = 1'b0;

    // Position inside a four-character group
    localparam logic [1:0] PHASE_STORE = 2'd0;
    localparam logic [1:0] PHASE_ONE   = 2'd1;
    localparam logic [1:0] PHASE_TWO   = 2'd2;
    localparam logic [1:0] PHASE_THREE = 2'd3;

    // One decoded result word
    typedef struct packed {
        logic [CHAR_W-1:0] data;
        logic              valid;
        logic              last;
    } t_result;

    // URL-safe alphabet, with '/' also giving 63; anything else is 0xFF
    function automatic logic [CHAR_W-1:0] map_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        v = BAD_VALUE;
        if (c >= "A" && c <= "Z") begin
            v = c - 8'd65;
        end else if (c >= "a" && c <= "z") begin
            v = c - 8'd71;
        end else if (c >= "0" && c <= "9") begin
            v = c + 8'd4;
        end else if (c == "-") begin
            v = CODE_DASH;
        end else if (c == "_" || c == "/") begin
            v = CODE_SLASH;
        end
        return v;
    endfunction

endpackage

// ===== hdl/b64d_step.sv =====
// Per-run decode state and the combinational step from one character to one result.
module b64d_step (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_advance,
    input  logic [b64d_pkg::CHAR_W-1:0]    i_char,
    input  logic                           i_last,
    input  logic [b64d_pkg::COUNT_W-1:0]   i_out_limit,
    output b64d_pkg::t_result              o_result
);
    import b64d_pkg::*;

    logic [1:0]         r_phase, n_phase;
    logic [CHAR_W-1:0]  r_prev, n_prev;
    logic               r_halted, n_halted;
    logic [COUNT_W-1:0] r_count, n_count;

    logic [CHAR_W-1:0]  value;
    logic [CHAR_W-1:0]  byte_out;
    logic               byte_ok;

    assign value = map_char(i_char);

    // Assemble the byte for the current phase
    always_comb begin
        byte_out = '0;
        byte_ok  = 1'b0;
        unique case (r_phase)
            PHASE_STORE: begin
                byte_out = '0;
                byte_ok  = 1'b0;
            end
            PHASE_ONE: begin
                byte_out = (r_prev << 2) | (value >> 4);
                byte_ok  = 1'b1;
            end
            PHASE_TWO: begin
                byte_out = (r_prev << 4) | (value >> 2);
                byte_ok  = 1'b1;
            end
            PHASE_THREE: begin
                byte_out = (r_prev << 6) | value;
                byte_ok  = 1'b1;
            end
            default: begin
                byte_out = '0;
                byte_ok  = 1'b0;
            end
        endcase
    end

    // Next state and result
    always_comb begin
        n_phase  = r_phase;
        n_prev   = r_prev;
        n_halted = r_halted;
        n_count  = r_count;
        o_result = '{data: '0, valid: 1'b0, last: i_last};
        if (!r_halted) begin
            if (i_char == '0) begin
                n_halted = 1'b1;
            end else begin
                n_prev  = value;
                n_phase = r_phase + 2'd1;
                if (byte_ok) begin
                    o_result.data  = byte_out;
                    o_result.valid = 1'b1;
                    n_count        = r_count + 16'd1;
                    if (n_count >= i_out_limit) begin
                        n_halted = 1'b1;
                    end
                end
            end
        end
        // end of run returns everything to the start
        if (i_last) begin
            n_phase  = PHASE_STORE;
            n_prev   = '0;
            n_halted = 1'b0;
            n_count  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PHASE_STORE;
            r_prev   <= '0;
            r_halted <= 1'b0;
            r_count  <= '0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_prev   <= n_prev;
            r_halted <= n_halted;
            r_count  <= n_count;
        end
    end

endmodule

// ===== hdl/base64url_stream_decoder.sv =====
// Base64url stream decoder: input register, decode step, output register, APB limit register.
// An accepted word waits in the input register and moves on to the output register once free.
// Throughput: one character word per cycle when not stalled; the state of a run is kept in
// b64d_step and advances as each word moves from the input register into the output register.
// Reset (synchronous, active low) empties both registers, clears the run state and sets
// out_limit to 65535.
module base64url_stream_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave side: tdata = in_char[7:0]; tlast = in_last
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [b64d_pkg::CHAR_W-1:0]   i_s_axis_tdata,
    input  logic                          i_s_axis_tlast,
    // master side: tdata = out_byte[7:0]; tuser = byte_valid; tlast = run_end
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [b64d_pkg::CHAR_W-1:0]   o_m_axis_tdata,
    output logic                          o_m_axis_tuser,
    output logic                          o_m_axis_tlast,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [b64d_pkg::ADDR_W-1:0]   paddr,
    input  logic [b64d_pkg::APB_W-1:0]    pwdata,
    output logic [b64d_pkg::APB_W-1:0]    prdata,
    output logic                          pready
);
    import b64d_pkg::*;

    logic               r_in_valid;
    logic [CHAR_W-1:0]  r_in_char;
    logic               r_in_last;
    logic               r_out_valid;
    t_result            r_out;
    logic [COUNT_W-1:0] r_out_limit;

    t_result            step_result;
    logic               advance;
    logic               out_free;
    logic               in_take;

    // Handshakes
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_char <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    b64d_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_char      (r_in_char),
        .i_last      (r_in_last),
        .i_out_limit (r_out_limit),
        .o_result    (step_result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.data;
    assign o_m_axis_tuser  = r_out.valid;
    assign o_m_axis_tlast  = r_out.last;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_OUT_LIMIT) begin
            r_out_limit <= pwdata[COUNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_OUT_LIMIT) ? {{(APB_W-COUNT_W){1'b0}}, r_out_limit}
                                                 : '0;

endmodule

// ===== hdl/b64d_checker.sv =====
// Port-level checks for the base64url stream decoder, bound to the top level.
module b64d_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic [b64d_pkg::CHAR_W-1:0]   o_m_axis_tdata,
    input  logic                          o_m_axis_tuser,
    input  logic                          o_m_axis_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [b64d_pkg::ADDR_W-1:0]   paddr,
    input  logic [b64d_pkg::APB_W-1:0]    pwdata,
    input  logic [b64d_pkg::APB_W-1:0]    prdata
);
    import b64d_pkg::*;

    // Output register is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
            && $stable(o_m_axis_tuser))
        else $error("stalled output word changed");

    // Words without a decoded byte carry zero data
    a_empty_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("nonzero data on word without a byte");

    // A limit write reads back at the same address
    a_limit_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && paddr[2] == REG_OUT_LIMIT && !$past(!i_rst_n) |=>
            (paddr[2] != REG_OUT_LIMIT)
            || prdata == {{(APB_W-COUNT_W){1'b0}}, $past(pwdata[COUNT_W-1:0])})
        else $error("out_limit readback mismatch");

endmodule

bind base64url_stream_decoder b64d_checker u_b64d_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata)
);

// ===== sim/base64url_stream_decoder_test.sv =====
// Self-checking testbench for the base64url stream decoder: stream traffic, limit writes.
`timescale 1ns / 100ps

module base64url_stream_decoder_test;

    import b64d_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN       = 8;
    localparam int RAND_ITEMS  = 1700;
    localparam int MAX_REPORTS = 30;

    // One character word waiting for the slave side
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_char_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [CHAR_W-1:0]   i_s_axis_tdata = '0;   // in_char[7:0]
    logic                i_s_axis_tlast = 1'b0; // in_last
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [CHAR_W-1:0]   o_m_axis_tdata;        // out_byte[7:0]
    logic                o_m_axis_tuser;        // byte_valid
    logic                o_m_axis_tlast;        // run_end
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [APB_W-1:0]    pwdata = '0;
    logic [APB_W-1:0]    prdata;
    logic                pready;

    base64url_stream_decoder uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    t_char_word  char_q[$];
    t_result     byte_q[$];

    // Decoder state mirror
    logic [COUNT_W-1:0] limit_cfg   = LIMIT_RESET;
    logic [1:0]         grp_phase   = PHASE_STORE;
    logic [CHAR_W-1:0]  last_sextet = '0;
    logic               stopped     = 1'b0;
    logic [COUNT_W-1:0] byte_count  = '0;

    int err_cnt     = 0;
    int chars_sent  = 0;
    int words_seen  = 0;
    int bytes_seen  = 0;
    int runs_seen   = 0;
    int limit_sets  = 0;
    int cycle_cnt   = 0;

    // URL-safe alphabet lookup, '/' doubles as 63, anything else reads as 0xFF
    function automatic logic [CHAR_W-1:0] sextet_of(input logic [CHAR_W-1:0] c);
        if (c >= "A" && c <= "Z") return c - "A";
        if (c >= "a" && c <= "z") return c - "a" + 8'd26;
        if (c >= "0" && c <= "9") return c - "0" + 8'd52;
        if (c == "-") return CODE_DASH;
        if (c == "_" || c == "/") return CODE_SLASH;
        return BAD_VALUE;
    endfunction

    // Index 0..64 to an alphabet character; 64 picks the '/' alias
    function automatic logic [CHAR_W-1:0] alpha_char(input int idx);
        if (idx < 26) return 8'("A" + idx);
        if (idx < 52) return 8'("a" + idx - 26);
        if (idx < 62) return 8'("0" + idx - 52);
        if (idx == 62) return "-";
        if (idx == 63) return "_";
        return "/";
    endfunction

    // Advance the mirror by one accepted character and queue the expected word
    task automatic decode_char(input logic [CHAR_W-1:0] ch, input logic last);
        t_result           res;
        logic [CHAR_W-1:0] v;
        res = '0;
        res.last = last;
        if (!stopped) begin
            if (ch == 8'h00) begin
                stopped = 1'b1;
            end else begin
                v = sextet_of(ch);
                case (grp_phase)
                    PHASE_ONE: begin
                        res.data = (last_sextet << 2) | (v >> 4);
                        res.valid = 1'b1;
                    end
                    PHASE_TWO: begin
                        res.data = (last_sextet << 4) | (v >> 2);
                        res.valid = 1'b1;
                    end
                    PHASE_THREE: begin
                        res.data = (last_sextet << 6) | v;
                        res.valid = 1'b1;
                    end
                    default: ;
                endcase
                last_sextet = v;
                grp_phase = grp_phase + 2'd1;
                if (res.valid) begin
                    byte_count = byte_count + 1'b1;
                    if (byte_count >= limit_cfg) stopped = 1'b1;
                end
            end
        end
        if (last) begin
            grp_phase = PHASE_STORE;
            last_sextet = '0;
            stopped = 1'b0;
            byte_count = '0;
        end
        byte_q.push_back(res);
    endtask

    // Driver: bursts of words with random gaps, holds a word until accepted
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        logic accepted;
        accepted = i_s_axis_tvalid && o_s_axis_tready;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (i_s_axis_tvalid && !accepted) begin
            // hold the current word
        end else begin
            if (accepted) begin
                decode_char(char_q[0].ch, char_q[0].last);
                char_q.pop_front();
                chars_sent++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 120)
                                                           : $urandom_range(1, 12);
                    gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
                end
            end
            if (gap_left > 0) begin
                gap_left--;
                i_s_axis_tvalid <= 1'b0;
            end else if (char_q.size() > 0) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= char_q[0].ch;
                i_s_axis_tlast  <= char_q[0].last;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: rotating random stall mask, reloaded per segment
    logic [7:0] stall_mask = 8'hFF;
    int         seg_left   = 0;

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (seg_left <= 0) begin
                stall_mask = $urandom_range(0, 2) == 0 ? 8'hFF : 8'($urandom);
                seg_left = $urandom_range(8, 64);
            end
            seg_left--;
            stall_mask = {stall_mask[0], stall_mask[7:1]};
            i_m_axis_tready <= stall_mask[0];

            if (o_m_axis_tvalid && i_m_axis_tready) begin
                words_seen++;
                if (byte_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: unexpected word, actual data %h valid %b last %b",
                                 $time, o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                end else begin
                    want = byte_q.pop_front();
                    if (want.valid) bytes_seen++;
                    if (want.last) runs_seen++;
                    if (o_m_axis_tdata !== want.data || o_m_axis_tuser !== want.valid ||
                        o_m_axis_tlast !== want.last) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display({"%0t: word mismatch, expected data %h valid %b last %b,",
                                      " actual data %h valid %b last %b"}, $time,
                                     want.data, want.valid, want.last,
                                     o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_cnt, byte_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_char(input logic [CHAR_W-1:0] ch, input logic last);
        t_char_word w;
        w.ch = ch;
        w.last = last;
        char_q.push_back(w);
    endtask

    task automatic wait_idle();
        while (char_q.size() != 0 || i_s_axis_tvalid || byte_q.size() != 0)
            @(posedge i_clk);
    endtask

    // APB write of out_limit: setup cycle, then access cycle
    task automatic write_limit(input logic [COUNT_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_OUT_LIMIT, 2'b00};
        pwdata  <= {{(APB_W-COUNT_W){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limit_cfg = value;
        limit_sets++;
    endtask

    // One random run: mostly well-formed text, some noise, stray zeros and bad bytes
    task automatic add_random_run(output int len);
        int kind;
        int zero_at;
        logic [CHAR_W-1:0] ch;
        kind = $urandom_range(0, 9);
        len = $urandom_range(0, 9) == 0 ? $urandom_range(100, 400) : $urandom_range(1, 40);
        zero_at = $urandom_range(0, len - 1);
        for (int k = 0; k < len; k++) begin
            if (kind == 0)
                ch = 8'($urandom);
            else if (kind == 1 && k == zero_at)
                ch = 8'h00;
            else if (kind == 2 && $urandom_range(0, 7) == 0)
                ch = 8'($urandom_range(1, 255));
            else
                ch = alpha_char($urandom_range(0, 64));
            push_char(ch, k == len - 1);
        end
    endtask

    initial begin
        logic [COUNT_W-1:0] limits[8];
        int queued;
        int len;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: alphabet extremes, '/' alias, invalid bytes, short group at the end
        push_char("A", 0);  push_char("Z", 0);  push_char("a", 0);  push_char("z", 0);
        push_char("0", 0);  push_char("9", 0);  push_char("-", 0);  push_char("_", 0);
        push_char("/", 0);  push_char(8'hFF, 0); push_char(8'h80, 0); push_char("=", 1);
        // zero character stops output until the run ends
        push_char("Q", 0);  push_char("U", 0);  push_char(8'h00, 0);
        push_char("x", 0);  push_char("y", 0);  push_char("z", 1);
        // one-character run ends at phase zero
        push_char("B", 1);
        wait_idle();

        // smallest limit: one byte and then silence
        write_limit(16'd1);
        push_char("T", 0);  push_char("W", 0);  push_char("F", 0);  push_char("u", 1);
        wait_idle();

        // Random phases across a spread of limits
        limits[0] = 16'hFFFF;
        limits[1] = 16'd1;
        limits[2] = 16'd2;
        limits[3] = 16'd3;
        limits[4] = 16'($urandom_range(4, 12));
        limits[5] = 16'($urandom_range(13, 300));
        limits[6] = 16'($urandom_range(301, 65535));
        limits[7] = 16'hFFFF;
        foreach (limits[p]) begin
            write_limit(limits[p]);
            queued = 0;
            while (queued < RAND_ITEMS / 8) begin
                add_random_run(len);
                queued += len;
            end
            wait_idle();
        end

        repeat (DRAIN) @(posedge i_clk);
        $display("covered %0d characters in %0d runs, %0d decoded bytes, %0d result words",
                 chars_sent, runs_seen, bytes_seen, words_seen);
        $display("limit register written %0d times, %0d errors", limit_sets, err_cnt);
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
